@@ design/rsp_pkg.sv @@
package rsp_pkg;

  localparam int SRC_W    = 2;
  localparam int SLOT_W   = 8;
  localparam int SLOTS    = 16;
  localparam int WORD_W   = 64;
  localparam int ID_W     = 32;
  localparam int TIME_W   = 32;
  localparam int BTN_W    = 16;

  localparam int NUM_SOURCES_DEF = 4;
  localparam int NUM_BUTTONS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 8;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd250000;

  // tracker -> lane update control
  typedef struct packed {
    logic             wr;
    logic             restart;
    logic [SRC_W-1:0] src;
  } upd_t;

endpackage

@@ design/rsp_in_if.sv @@
interface rsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [rsp_pkg::SRC_W-1:0]   source_id;
  logic                        available;
  logic                        snap_valid;
  logic [rsp_pkg::ID_W-1:0]    session_id;
  logic [rsp_pkg::ID_W-1:0]    seq_number;
  logic [rsp_pkg::TIME_W-1:0]  snap_time_us;
  logic [rsp_pkg::TIME_W-1:0]  now_time_us;
  logic [rsp_pkg::WORD_W-1:0]  counts_low;
  logic [rsp_pkg::WORD_W-1:0]  counts_high;
  logic [rsp_pkg::BTN_W-1:0]   button_levels;

  modport source (
    output valid, source_id, available, snap_valid, session_id, seq_number,
           snap_time_us, now_time_us, counts_low, counts_high, button_levels,
    input  ready
  );
  modport sink (
    input  valid, source_id, available, snap_valid, session_id, seq_number,
           snap_time_us, now_time_us, counts_low, counts_high, button_levels,
    output ready
  );
endinterface

@@ design/rsp_out_if.sv @@
interface rsp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        in_order;
  logic                        is_fresh;
  logic [rsp_pkg::BTN_W-1:0]   new_presses;
  logic [rsp_pkg::BTN_W-1:0]   held_out;
  logic [rsp_pkg::TIME_W-1:0]  time_out_us;

  modport source (
    output valid, in_order, is_fresh, new_presses, held_out, time_out_us,
    input  ready
  );
  modport sink (
    input  valid, in_order, is_fresh, new_presses, held_out, time_out_us,
    output ready
  );
endinterface

@@ design/rsp_lane.sv @@
// One button: per-source counter store and change detect.
module rsp_lane #(
  parameter int NUM_SOURCES = rsp_pkg::NUM_SOURCES_DEF,
  parameter int COUNT_BITS  = rsp_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsp_pkg::upd_t         upd,
  input  logic [COUNT_BITS-1:0] cnt_in,
  output logic                  press
);

  logic [COUNT_BITS-1:0] cnt_r [NUM_SOURCES];
  logic [COUNT_BITS-1:0] cnt_sel;
  logic [COUNT_BITS-1:0] cnt_old;

  always_comb begin
    cnt_sel = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (s == int'(upd.src)) begin
        cnt_sel = cnt_r[s];
      end
    end
  end

  // a new stream starts from zeroed counters
  assign cnt_old = upd.restart ? '0 : cnt_sel;
  assign press   = (cnt_in != cnt_old);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        cnt_r[s] <= '0;
      end
    end else begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        if (upd.wr && s == int'(upd.src)) begin
          cnt_r[s] <= cnt_in;
        end
      end
    end
  end

endmodule

@@ design/rsp_tracker.sv @@
// Per-source stream/sequence state and the ordering decision.
module rsp_tracker #(
  parameter int NUM_SOURCES = rsp_pkg::NUM_SOURCES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [rsp_pkg::SRC_W-1:0] src,
  input  logic                      avail,
  input  logic                      snap_valid,
  input  logic [rsp_pkg::ID_W-1:0]  session_id,
  input  logic [rsp_pkg::ID_W-1:0]  seq_number,
  output logic                      take,
  output rsp_pkg::upd_t             upd
);

  logic                     started_r [NUM_SOURCES];
  logic [rsp_pkg::ID_W-1:0] stream_r  [NUM_SOURCES];
  logic [rsp_pkg::ID_W-1:0] seq_r     [NUM_SOURCES];

  logic                     started_sel;
  logic [rsp_pkg::ID_W-1:0] stream_sel;
  logic [rsp_pkg::ID_W-1:0] seq_sel;
  logic [rsp_pkg::ID_W-1:0] seq_diff;
  logic                     hit;
  logic                     changed;
  logic                     ordered;

  always_comb begin
    started_sel = 1'b0;
    stream_sel  = '0;
    seq_sel     = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (s == int'(src)) begin
        started_sel = started_r[s];
        stream_sel  = stream_r[s];
        seq_sel     = seq_r[s];
      end
    end
  end

  assign hit      = avail && (int'(src) < NUM_SOURCES);
  assign changed  = !started_sel || (stream_sel != session_id);
  // serial compare: older when the wrapped difference is negative
  assign seq_diff = seq_number - seq_sel;
  assign ordered  = changed || !snap_valid || !seq_diff[rsp_pkg::ID_W-1];
  assign take     = hit && ordered;

  assign upd.wr      = accept && take;
  assign upd.restart = changed;
  assign upd.src     = src;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        started_r[s] <= 1'b0;
        stream_r[s]  <= '0;
        seq_r[s]     <= '0;
      end
    end else begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        if (upd.wr && s == int'(src)) begin
          started_r[s] <= 1'b1;
          stream_r[s]  <= session_id;
          seq_r[s]     <= seq_number;
        end
      end
    end
  end

endmodule

@@ design/rsp_merge.sv @@
// Combines lane results with freshness and holds the result register.
module rsp_merge #(
  parameter int NUM_BUTTONS = rsp_pkg::NUM_BUTTONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       take,
  input  logic                       snap_valid,
  input  logic [rsp_pkg::TIME_W-1:0] snap_time_us,
  input  logic [rsp_pkg::TIME_W-1:0] now_time_us,
  input  logic [rsp_pkg::TIME_W-1:0] timeout_us,
  input  logic [rsp_pkg::BTN_W-1:0]  button_levels,
  input  logic [NUM_BUTTONS-1:0]     presses,
  output logic                       can_take,
  rsp_out_if.source                  out_ch
);

  localparam logic [rsp_pkg::BTN_W-1:0] BMASK =
    rsp_pkg::BTN_W'((33'd1 << NUM_BUTTONS) - 33'd1);

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       in_order_r;
  logic                       fresh_r;
  logic [rsp_pkg::BTN_W-1:0]  presses_r;
  logic [rsp_pkg::BTN_W-1:0]  held_r;
  logic [rsp_pkg::TIME_W-1:0] time_r;

  logic [rsp_pkg::TIME_W-1:0] age;
  logic                       fresh;

  assign age   = now_time_us - snap_time_us;
  assign fresh = take && snap_valid && (snap_time_us != '0) && (age <= timeout_us);

  assign can_take = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_order_r <= take;
      fresh_r    <= fresh;
      presses_r  <= fresh ? (rsp_pkg::BTN_W'(presses) & BMASK) : '0;
      held_r     <= fresh ? (button_levels & BMASK) : '0;
      time_r     <= take ? snap_time_us : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.in_order    = in_order_r;
  assign out_ch.is_fresh    = fresh_r;
  assign out_ch.new_presses = presses_r;
  assign out_ch.held_out    = held_r;
  assign out_ch.time_out_us = time_r;

endmodule

@@ design/remote_snapshot_press_tracker.sv @@
// Remote snapshot press tracker: takes one snapshot item per clock and returns one
// result item the cycle after acceptance, from an output register, so a steady stream
// runs at one item per cycle while the sink keeps ready high. Per-source stream id and
// sequence state and the per-button press counters (one lane per button) are read,
// compared and written back in the cycle the item is accepted, which is what holds the
// rate at one item per cycle even for back-to-back items from the same source.
// timeout_us resets to 250000; write cfg_we/cfg_data only while idle (unenforced).
module remote_snapshot_press_tracker #(
  parameter int NUM_SOURCES = rsp_pkg::NUM_SOURCES_DEF,
  parameter int NUM_BUTTONS = rsp_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_BITS  = rsp_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rsp_pkg::TIME_W-1:0] cfg_data,
  rsp_in_if.sink                     in_if,
  rsp_out_if.source                  out_if
);

  logic [rsp_pkg::TIME_W-1:0] timeout_r;
  logic                       accept;
  logic                       take;
  logic                       can_take;
  rsp_pkg::upd_t              upd;
  logic [NUM_BUTTONS-1:0]     presses;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rsp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  assign in_if.ready = can_take;
  assign accept      = in_if.valid && can_take;

  rsp_tracker #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .src        (in_if.source_id),
    .avail      (in_if.available),
    .snap_valid (in_if.snap_valid),
    .session_id (in_if.session_id),
    .seq_number (in_if.seq_number),
    .take       (take),
    .upd        (upd)
  );

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic [COUNT_BITS-1:0] cnt;
    if (b < rsp_pkg::SLOTS / 2) begin : g_lo
      assign cnt = in_if.counts_low[b*rsp_pkg::SLOT_W +: COUNT_BITS];
    end else begin : g_hi
      assign cnt = in_if.counts_high[(b - rsp_pkg::SLOTS / 2)*rsp_pkg::SLOT_W +: COUNT_BITS];
    end

    rsp_lane #(
      .NUM_SOURCES (NUM_SOURCES),
      .COUNT_BITS  (COUNT_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .upd    (upd),
      .cnt_in (cnt),
      .press  (presses[b])
    );
  end

  rsp_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .take          (take),
    .snap_valid    (in_if.snap_valid),
    .snap_time_us  (in_if.snap_time_us),
    .now_time_us   (in_if.now_time_us),
    .timeout_us    (timeout_r),
    .button_levels (in_if.button_levels),
    .presses       (presses),
    .can_take      (can_take),
    .out_ch        (out_if)
  );

endmodule

@@ design/rsp_checker.sv @@
module rsp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       in_order,
  input logic                       is_fresh,
  input logic [rsp_pkg::BTN_W-1:0]  new_presses,
  input logic [rsp_pkg::BTN_W-1:0]  held_out,
  input logic [rsp_pkg::TIME_W-1:0] time_out_us
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_stale_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_fresh |-> new_presses == '0 && held_out == '0)
    else $error("stale result carries buttons");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_order |-> !is_fresh && time_out_us == '0)
    else $error("rejected result not cleared");

  a_fresh_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_fresh |-> in_order && time_out_us != '0)
    else $error("fresh result without timestamp");

endmodule

bind remote_snapshot_press_tracker rsp_checker u_rsp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .in_order    (out_if.in_order),
  .is_fresh    (out_if.is_fresh),
  .new_presses (out_if.new_presses),
  .held_out    (out_if.held_out),
  .time_out_us (out_if.time_out_us)
);
